// ===== hdl/hfus_pkg.sv =====
`default_nettype none
package hfus_pkg;

  // Queue depth between front and back, and of the result queue
  localparam int QUEUE_DEPTH = 2;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_TIME_STEP      = 3'd0;
  localparam logic [2:0] REG_INV_TIME_STEP  = 3'd1;
  localparam logic [2:0] REG_ALPHA_TILT     = 3'd2;
  localparam logic [2:0] REG_ALPHA_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_ALPHA_VELOCITY = 3'd4;
  localparam logic [2:0] REG_STEP_LIMIT     = 3'd5;
  localparam logic [2:0] REG_KP_GAIN        = 3'd6;
  localparam logic [2:0] REG_KI_GAIN        = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_TIME_STEP      = 16'd1311;
  localparam logic [9:0]  RST_INV_TIME_STEP  = 10'd50;
  localparam logic [15:0] RST_ALPHA_TILT     = 16'd54067;
  localparam logic [15:0] RST_ALPHA_HEIGHT   = 16'd32768;
  localparam logic [15:0] RST_ALPHA_VELOCITY = 16'd32768;
  localparam logic [15:0] RST_STEP_LIMIT     = 16'd9830;
  localparam logic [15:0] RST_KP_GAIN        = 16'd39322;
  localparam logic [15:0] RST_KI_GAIN        = 16'd1311;

  // Range selection limits, millimetres
  localparam logic [15:0] RANGE_MAX_MM = 16'd8000;
  localparam logic [13:0] SENTINEL_MM  = 14'd8192;
  localparam logic [13:0] VALID_MAX_MM = 14'd4000;
  localparam logic [7:0]  STATUS_OK_A  = 8'd5;
  localparam logic [7:0]  STATUS_OK_B  = 8'd9;

  // Fixed-point constants
  localparam logic signed [16:0] COS_MIN        = 17'sd9830;
  localparam logic signed [16:0] COS_MAX        = 17'sd32768;
  localparam logic [16:0]        Q16_ONE        = 17'd65536;
  localparam logic [32:0]        VZ_NORM_Q16    = 33'd19661;
  localparam logic [32:0]        VZ_SPAN_Q16    = 33'd45875;
  localparam logic signed [63:0] INTEGRAL_LIMIT = 64'sd131072;
  localparam logic [15:0]        LEAK_Q16       = 16'd65503;

  // Divider
  localparam int DIV_W = 36;
  localparam logic [15:0] DIV_MM_SCALE = 16'd1000;
  localparam logic [15:0] DIV_Q_SPAN   = 16'd45875;

  typedef enum logic {DIV_BY_THOUSAND, DIV_BY_SPAN} divisor_t;

  typedef struct packed {
    logic signed [18:0] accel_z;
    logic signed [16:0] tilt_cosine;
    logic [13:0]        range_mm;
    logic               range_ok;
  } item_t;

  typedef struct packed {
    logic signed [31:0] vertical_velocity;
    logic signed [31:0] height_out;
    logic               laser_ok;
  } result_t;

  typedef struct packed {
    logic [15:0] time_step;
    logic [9:0]  inverse_time_step;
    logic [15:0] alpha_tilt;
    logic [15:0] alpha_height;
    logic [15:0] alpha_velocity;
    logic [15:0] step_limit;
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
  } cfg_t;

  typedef struct packed {
    logic           start;
    divisor_t       sel;
    logic [DIV_W-1:0] num;
  } div_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ACC_MUL, S_ACC_DIV_GO, S_ACC_DIV_WAIT, S_DR_MUL, S_DR_UPD,
    S_TILT_MUL, S_TILT_UPD, S_H_MUL, S_H_DIV_GO, S_H_DIV_WAIT,
    S_HF_MUL, S_HF_UPD, S_VR_MUL, S_VF_MUL, S_VF_UPD, S_Q,
    S_Q_DIV_GO, S_Q_DIV_WAIT, S_KI_MUL, S_KI_ERR, S_KI_DT, S_CI_UPD,
    S_KP_MUL, S_KP_ERR, S_V_UPD, S_LEAK_MUL, S_LEAK_UPD
  } state_t;

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Shift right by 16, rounding to nearest, ties away from zero
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    logic signed [63:0] m;
    m = (x < 0) ? -x : x;
    m = (m + 64'sd32768) >>> 16;
    return (x < 0) ? -m : m;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/laser_accel_height_fusion_core.sv =====
`default_nettype none
// Vertical velocity and height fusion of accelerometer and downward laser range.
// One result per input transaction, in order. Input transactions are classified
// on entry (range selection and validity) and queued; a sequencer with one
// shared 34x18 multiplier and a reciprocal-multiply divider then runs the
// filter. A transaction with an invalid range ends after the acceleration
// division and the dead-reckoning step, a recovery frame after the height
// division, and a normal frame runs the whole filter, with a third division
// when the velocity quality needs one. The result then shows on the outputs
// through the result queue, and the next transaction is taken once the back
// end is idle and the result queue has room. Configuration writes take
// effect at once and should be made idle.
module laser_accel_height_fusion_core #(
  parameter int QUEUE_DEPTH = hfus_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [18:0] accel_z,
  input  wire logic [7:0]         zone_status_a,
  input  wire logic [7:0]         zone_status_b,
  input  wire logic [7:0]         zone_status_c,
  input  wire logic [7:0]         zone_status_d,
  input  wire logic [15:0]        zone_range_a,
  input  wire logic [15:0]        zone_range_b,
  input  wire logic [15:0]        zone_range_c,
  input  wire logic [15:0]        zone_range_d,
  input  wire logic [15:0]        fallback_range,
  input  wire logic signed [16:0] tilt_cosine,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      vertical_velocity,
  output logic signed [31:0]      height_out,
  output logic                    laser_ok,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  hfus_pkg::cfg_t    cfg;
  hfus_pkg::item_t   fr_item, bk_item;
  hfus_pkg::result_t res_in, res_out;
  logic              iq_empty, iq_pop, rq_full, rq_push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step         <= hfus_pkg::RST_TIME_STEP;
      cfg.inverse_time_step <= hfus_pkg::RST_INV_TIME_STEP;
      cfg.alpha_tilt        <= hfus_pkg::RST_ALPHA_TILT;
      cfg.alpha_height      <= hfus_pkg::RST_ALPHA_HEIGHT;
      cfg.alpha_velocity    <= hfus_pkg::RST_ALPHA_VELOCITY;
      cfg.step_limit        <= hfus_pkg::RST_STEP_LIMIT;
      cfg.kp_gain           <= hfus_pkg::RST_KP_GAIN;
      cfg.ki_gain           <= hfus_pkg::RST_KI_GAIN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hfus_pkg::REG_TIME_STEP:      cfg.time_step         <= cfg_data;
        hfus_pkg::REG_INV_TIME_STEP:  cfg.inverse_time_step <= cfg_data[9:0];
        hfus_pkg::REG_ALPHA_TILT:     cfg.alpha_tilt        <= cfg_data;
        hfus_pkg::REG_ALPHA_HEIGHT:   cfg.alpha_height      <= cfg_data;
        hfus_pkg::REG_ALPHA_VELOCITY: cfg.alpha_velocity    <= cfg_data;
        hfus_pkg::REG_STEP_LIMIT:     cfg.step_limit        <= cfg_data;
        hfus_pkg::REG_KP_GAIN:        cfg.kp_gain           <= cfg_data;
        hfus_pkg::REG_KI_GAIN:        cfg.ki_gain           <= cfg_data;
        default: ;
      endcase
    end
  end

  hfus_front u_front (
    .accel_z        (accel_z),
    .zone_status_a  (zone_status_a),
    .zone_status_b  (zone_status_b),
    .zone_status_c  (zone_status_c),
    .zone_status_d  (zone_status_d),
    .zone_range_a   (zone_range_a),
    .zone_range_b   (zone_range_b),
    .zone_range_c   (zone_range_c),
    .zone_range_d   (zone_range_d),
    .fallback_range (fallback_range),
    .tilt_cosine    (tilt_cosine),
    .item           (fr_item)
  );

  hfus_queue #(.WIDTH($bits(hfus_pkg::item_t)), .DEPTH(QUEUE_DEPTH)) u_in_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (fr_item),
    .full  (full),
    .pop   (iq_pop),
    .dout  (bk_item),
    .empty (iq_empty)
  );

  hfus_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_item  (bk_item),
    .in_empty (iq_empty),
    .in_pop   (iq_pop),
    .res_full (rq_full),
    .res_push (rq_push),
    .res_data (res_in)
  );

  hfus_queue #(.WIDTH($bits(hfus_pkg::result_t)), .DEPTH(QUEUE_DEPTH)) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .din   (res_in),
    .full  (rq_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign vertical_velocity = res_out.vertical_velocity;
  assign height_out        = res_out.height_out;
  assign laser_ok          = res_out.laser_ok;
endmodule
`default_nettype wire

// ===== hdl/hfus_queue.sv =====
`default_nettype none
module hfus_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/hfus_front.sv =====
`default_nettype none
module hfus_front (
  input  wire logic signed [18:0] accel_z,
  input  wire logic [7:0]         zone_status_a,
  input  wire logic [7:0]         zone_status_b,
  input  wire logic [7:0]         zone_status_c,
  input  wire logic [7:0]         zone_status_d,
  input  wire logic [15:0]        zone_range_a,
  input  wire logic [15:0]        zone_range_b,
  input  wire logic [15:0]        zone_range_c,
  input  wire logic [15:0]        zone_range_d,
  input  wire logic [15:0]        fallback_range,
  input  wire logic signed [16:0] tilt_cosine,
  output hfus_pkg::item_t         item
);
  logic [3:0]  ok;
  logic [15:0] rng [4];
  logic [7:0]  sts [4];
  logic [15:0] best;
  logic        any;
  logic [13:0] mm;

  assign rng[0] = zone_range_a;
  assign rng[1] = zone_range_b;
  assign rng[2] = zone_range_c;
  assign rng[3] = zone_range_d;
  assign sts[0] = zone_status_a;
  assign sts[1] = zone_status_b;
  assign sts[2] = zone_status_c;
  assign sts[3] = zone_status_d;

  // zone qualification
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ok[i] = (sts[i] == hfus_pkg::STATUS_OK_A || sts[i] == hfus_pkg::STATUS_OK_B) &&
              (rng[i] != 16'd0) && (rng[i] < hfus_pkg::RANGE_MAX_MM);
    end
  end

  // farthest valid zone, else fallback, else sentinel
  always_comb begin
    best = '0;
    for (int i = 0; i < 4; i++) begin
      if (ok[i] && rng[i] > best) best = rng[i];
    end
    any = |ok;
    if (any) begin
      mm = best[13:0];
    end else if (fallback_range > 16'd1 && fallback_range < hfus_pkg::RANGE_MAX_MM) begin
      mm = fallback_range[13:0];
    end else begin
      mm = hfus_pkg::SENTINEL_MM;
    end
  end

  assign item.accel_z     = accel_z;
  assign item.tilt_cosine = tilt_cosine;
  assign item.range_mm    = mm;
  assign item.range_ok    = (mm <= hfus_pkg::VALID_MAX_MM) && (mm > 14'd1);
endmodule
`default_nettype wire

// ===== hdl/hfus_div.sv =====
`default_nettype none
module hfus_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  hfus_pkg::div_req_t                req,
  output logic                              done,
  output logic [hfus_pkg::DIV_W-1:0]        quot
);
  // The numerator stays below 2^34, so a reciprocal scaled by 2^34 and
  // rounded down leaves the estimate at most one short of the true quotient;
  // one compare and subtract on the remainder settles it.
  localparam int NW = 34;
  localparam int RW = 25;
  localparam int PW = NW + RW;
  localparam logic [RW-1:0] RCP_MM_SCALE = 25'd17179869;  // floor(2^34 / 1000)
  localparam logic [RW-1:0] RCP_Q_SPAN   = 25'd374493;    // floor(2^34 / 45875)

  logic [hfus_pkg::DIV_W-1:0] num, qd;
  hfus_pkg::divisor_t         div_sel;
  logic [15:0]                dvs, req_dvs;
  logic [PW-1:0]              prod, prod_next;
  logic [RW-1:0]              qe;
  logic [16:0]                rem;
  logic                       num_vld, prod_vld, rem_vld;

  assign req_dvs = (req.sel == hfus_pkg::DIV_BY_SPAN) ? hfus_pkg::DIV_Q_SPAN
                                                      : hfus_pkg::DIV_MM_SCALE;

  // reciprocal product and back-multiplied estimate, by constants only
  always_comb begin
    if (div_sel == hfus_pkg::DIV_BY_SPAN) begin
      dvs       = hfus_pkg::DIV_Q_SPAN;
      prod_next = PW'(num[NW-1:0]) * PW'(RCP_Q_SPAN);
      qd        = hfus_pkg::DIV_W'(prod[PW-1:NW]) * hfus_pkg::DIV_W'(hfus_pkg::DIV_Q_SPAN);
    end else begin
      dvs       = hfus_pkg::DIV_MM_SCALE;
      prod_next = PW'(num[NW-1:0]) * PW'(RCP_MM_SCALE);
      qd        = hfus_pkg::DIV_W'(prod[PW-1:NW]) * hfus_pkg::DIV_W'(hfus_pkg::DIV_MM_SCALE);
    end
  end

  // stage flags; done pulses once start has passed through num_vld, prod_vld and rem_vld
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vld  <= 1'b0;
      prod_vld <= 1'b0;
      rem_vld  <= 1'b0;
      done     <= 1'b0;
    end else begin
      num_vld  <= req.start;
      prod_vld <= num_vld;
      rem_vld  <= prod_vld;
      done     <= rem_vld;
    end
  end

  // datapath; half divisor added for rounding
  always_ff @(posedge clk) begin
    if (req.start) begin
      num     <= req.num + hfus_pkg::DIV_W'(req_dvs >> 1);
      div_sel <= req.sel;
    end
    prod <= prod_next;
    qe   <= prod[PW-1:NW];
    rem  <= 17'(num - qd);
    if (rem_vld) begin
      quot <= (rem >= {1'b0, dvs}) ? hfus_pkg::DIV_W'(qe) + 1'b1 : hfus_pkg::DIV_W'(qe);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/hfus_back.sv =====
`default_nettype none
module hfus_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  hfus_pkg::cfg_t         cfg,
  input  hfus_pkg::item_t        in_item,
  input  wire logic              in_empty,
  output logic                   in_pop,
  input  wire logic              res_full,
  output logic                   res_push,
  output hfus_pkg::result_t      res_data
);
  hfus_pkg::state_t   state, state_next;
  hfus_pkg::item_t    cur;
  hfus_pkg::div_req_t dreq;
  logic               ddone;
  logic [hfus_pkg::DIV_W-1:0] dquot;

  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] p;
  logic signed [63:0] pr, sq;

  logic signed [31:0] av, dr, hf, pv, vf, ci, h, hl, vtmp;
  logic signed [16:0] tf, cclamp;
  logic signed [16:0] dz;
  logic [16:0]        q;
  logic               neg, lost;
  logic signed [32:0] err, dzd, vabs;
  logic signed [31:0] hf_new, hl_new;
  logic signed [16:0] dz_new;
  logic signed [32:0] lim;
  logic signed [63:0] t_sum, v_sum;

  hfus_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quot (dquot)
  );

  // shared multiplier, registered
  assign pr = hfus_pkg::rnd16(64'(p));
  assign sq = neg ? -$signed({28'd0, dquot}) : $signed({28'd0, dquot});
  assign err = 33'(vf) - 33'(av);
  assign vabs = vf[31] ? -33'(vf) : 33'(vf);
  assign lim = $signed({17'd0, cfg.step_limit});

  // tilt clamp to 0.3..1.0
  always_comb begin
    if (tf < hfus_pkg::COS_MIN) cclamp = hfus_pkg::COS_MIN;
    else if (tf > hfus_pkg::COS_MAX) cclamp = hfus_pkg::COS_MAX;
    else cclamp = tf;
  end

  // filtered height, limited step
  always_comb begin
    hf_new = hfus_pkg::sat32(64'(hf) + pr);
    dzd    = 33'(hf_new) - 33'(pv);
    if (dzd > lim) dz_new = 17'(lim);
    else if (dzd < -lim) dz_new = 17'(-lim);
    else dz_new = 17'(dzd);
    hl_new = hfus_pkg::sat32(64'(pv) + 64'(dz_new));
    t_sum  = 64'(ci) + pr;
    v_sum  = 64'(av) + pr + 64'(ci);
  end

  // operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      hfus_pkg::S_ACC_MUL: begin
        mul_a = 34'(cur.accel_z);
        mul_b = $signed({2'b0, cfg.time_step});
      end
      hfus_pkg::S_DR_MUL: begin
        mul_a = 34'(av);
        mul_b = $signed({2'b0, cfg.time_step});
      end
      hfus_pkg::S_TILT_MUL: begin
        mul_a = 34'(18'(cur.tilt_cosine) - 18'(tf));
        mul_b = $signed({2'b0, cfg.alpha_tilt});
      end
      hfus_pkg::S_H_MUL: begin
        mul_a = $signed({20'd0, cur.range_mm});
        mul_b = 18'(cclamp);
      end
      hfus_pkg::S_HF_MUL: begin
        mul_a = 34'(33'(h) - 33'(hf));
        mul_b = $signed({2'b0, cfg.alpha_height});
      end
      hfus_pkg::S_VR_MUL: begin
        mul_a = 34'(dz);
        mul_b = $signed({8'd0, cfg.inverse_time_step});
      end
      hfus_pkg::S_VF_MUL: begin
        mul_a = 34'(64'(p) - 64'(vf));
        mul_b = $signed({2'b0, cfg.alpha_velocity});
      end
      hfus_pkg::S_KI_MUL: begin
        mul_a = $signed({17'd0, q});
        mul_b = $signed({2'b0, cfg.ki_gain});
      end
      hfus_pkg::S_KP_MUL: begin
        mul_a = $signed({17'd0, q});
        mul_b = $signed({2'b0, cfg.kp_gain});
      end
      hfus_pkg::S_KI_ERR, hfus_pkg::S_KP_ERR: begin
        mul_a = 34'(err);
        mul_b = 18'(pr);
      end
      hfus_pkg::S_KI_DT: begin
        mul_a = 34'(pr);
        mul_b = $signed({2'b0, cfg.time_step});
      end
      hfus_pkg::S_LEAK_MUL: begin
        mul_a = 34'(vtmp);
        mul_b = $signed({2'b0, hfus_pkg::LEAK_Q16});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= hfus_pkg::S_IDLE;
    else state <= state_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    in_pop     = 1'b0;
    res_push   = 1'b0;
    res_data   = '0;
    dreq       = '0;
    unique case (state)
      hfus_pkg::S_IDLE: begin
        if (!in_empty && !res_full) begin
          in_pop     = 1'b1;
          state_next = hfus_pkg::S_ACC_MUL;
        end
      end
      hfus_pkg::S_ACC_MUL: state_next = hfus_pkg::S_ACC_DIV_GO;
      hfus_pkg::S_ACC_DIV_GO: begin
        dreq.start = 1'b1;
        dreq.sel   = hfus_pkg::DIV_BY_THOUSAND;
        dreq.num   = p[51] ? hfus_pkg::DIV_W'(-64'(p)) : hfus_pkg::DIV_W'(p);
        state_next = hfus_pkg::S_ACC_DIV_WAIT;
      end
      hfus_pkg::S_ACC_DIV_WAIT: begin
        if (ddone) begin
          state_next = cur.range_ok ? hfus_pkg::S_TILT_MUL : hfus_pkg::S_DR_MUL;
        end
      end
      hfus_pkg::S_DR_MUL: state_next = hfus_pkg::S_DR_UPD;
      hfus_pkg::S_DR_UPD: begin
        res_push                   = 1'b1;
        res_data.vertical_velocity = av;
        res_data.height_out        = hfus_pkg::sat32(64'(dr) + pr);
        res_data.laser_ok          = 1'b0;
        state_next                 = hfus_pkg::S_IDLE;
      end
      hfus_pkg::S_TILT_MUL: state_next = hfus_pkg::S_TILT_UPD;
      hfus_pkg::S_TILT_UPD: state_next = hfus_pkg::S_H_MUL;
      hfus_pkg::S_H_MUL:    state_next = hfus_pkg::S_H_DIV_GO;
      hfus_pkg::S_H_DIV_GO: begin
        dreq.start = 1'b1;
        dreq.sel   = hfus_pkg::DIV_BY_THOUSAND;
        dreq.num   = hfus_pkg::DIV_W'(64'(p) <<< 1);
        state_next = hfus_pkg::S_H_DIV_WAIT;
      end
      hfus_pkg::S_H_DIV_WAIT: begin
        if (ddone) begin
          if (lost) begin
            res_push                   = 1'b1;
            res_data.vertical_velocity = av;
            res_data.height_out        = 32'(dquot);
            res_data.laser_ok          = 1'b1;
            state_next                 = hfus_pkg::S_IDLE;
          end else begin
            state_next = hfus_pkg::S_HF_MUL;
          end
        end
      end
      hfus_pkg::S_HF_MUL: state_next = hfus_pkg::S_HF_UPD;
      hfus_pkg::S_HF_UPD: state_next = hfus_pkg::S_VR_MUL;
      hfus_pkg::S_VR_MUL: state_next = hfus_pkg::S_VF_MUL;
      hfus_pkg::S_VF_MUL: state_next = hfus_pkg::S_VF_UPD;
      hfus_pkg::S_VF_UPD: state_next = hfus_pkg::S_Q;
      hfus_pkg::S_Q: begin
        if (vabs > $signed(hfus_pkg::VZ_NORM_Q16) &&
            vabs - $signed(hfus_pkg::VZ_NORM_Q16) < $signed(hfus_pkg::VZ_SPAN_Q16)) begin
          state_next = hfus_pkg::S_Q_DIV_GO;
        end else begin
          state_next = hfus_pkg::S_KI_MUL;
        end
      end
      hfus_pkg::S_Q_DIV_GO: begin
        dreq.start = 1'b1;
        dreq.sel   = hfus_pkg::DIV_BY_SPAN;
        dreq.num   = hfus_pkg::DIV_W'(
                       {1'b0, 33'(vabs - $signed(hfus_pkg::VZ_NORM_Q16))} << 16);
        state_next = hfus_pkg::S_Q_DIV_WAIT;
      end
      hfus_pkg::S_Q_DIV_WAIT: begin
        if (ddone) state_next = hfus_pkg::S_KI_MUL;
      end
      hfus_pkg::S_KI_MUL:   state_next = hfus_pkg::S_KI_ERR;
      hfus_pkg::S_KI_ERR:   state_next = hfus_pkg::S_KI_DT;
      hfus_pkg::S_KI_DT:    state_next = hfus_pkg::S_CI_UPD;
      hfus_pkg::S_CI_UPD:   state_next = hfus_pkg::S_KP_MUL;
      hfus_pkg::S_KP_MUL:   state_next = hfus_pkg::S_KP_ERR;
      hfus_pkg::S_KP_ERR:   state_next = hfus_pkg::S_V_UPD;
      hfus_pkg::S_V_UPD:    state_next = hfus_pkg::S_LEAK_MUL;
      hfus_pkg::S_LEAK_MUL: state_next = hfus_pkg::S_LEAK_UPD;
      hfus_pkg::S_LEAK_UPD: begin
        res_push                   = 1'b1;
        res_data.vertical_velocity = hfus_pkg::sat32(pr);
        res_data.height_out        = pv;
        res_data.laser_ok          = 1'b1;
        state_next                 = hfus_pkg::S_IDLE;
      end
      default: state_next = hfus_pkg::S_IDLE;
    endcase
  end

  // fusion state
  always_ff @(posedge clk) begin
    if (rst) begin
      av   <= '0;
      dr   <= '0;
      tf   <= hfus_pkg::COS_MAX;
      hf   <= '0;
      pv   <= '0;
      vf   <= '0;
      ci   <= '0;
      lost <= 1'b1;
    end else begin
      case (state)
        hfus_pkg::S_ACC_DIV_WAIT: if (ddone) av <= hfus_pkg::sat32(64'(av) + sq);
        hfus_pkg::S_DR_UPD: begin
          dr   <= hfus_pkg::sat32(64'(dr) + pr);
          lost <= 1'b1;
        end
        hfus_pkg::S_TILT_UPD: tf <= 17'(18'(tf) + 18'(pr));
        hfus_pkg::S_H_DIV_WAIT: begin
          if (ddone && lost) begin
            lost <= 1'b0;
            hf   <= 32'(dquot);
            pv   <= 32'(dquot);
            dr   <= 32'(dquot);
            vf   <= '0;
          end
        end
        hfus_pkg::S_HF_UPD: hf <= hf_new;
        hfus_pkg::S_VF_UPD: begin
          vf <= hfus_pkg::sat32(64'(vf) + pr);
          pv <= hl;
        end
        hfus_pkg::S_CI_UPD: begin
          if (t_sum > hfus_pkg::INTEGRAL_LIMIT) ci <= 32'(hfus_pkg::INTEGRAL_LIMIT);
          else if (t_sum < -hfus_pkg::INTEGRAL_LIMIT) ci <= 32'(-hfus_pkg::INTEGRAL_LIMIT);
          else ci <= 32'(t_sum);
        end
        hfus_pkg::S_LEAK_UPD: av <= hfus_pkg::sat32(pr);
        default: ;
      endcase
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk) begin
    if (in_pop) cur <= in_item;
    if (state == hfus_pkg::S_ACC_DIV_GO) neg <= p[51];
    if (state == hfus_pkg::S_H_DIV_WAIT && ddone) h <= 32'(dquot);
    if (state == hfus_pkg::S_HF_UPD) begin
      dz <= dz_new;
      hl <= hl_new;
    end
    if (state == hfus_pkg::S_Q) q <= (vabs > $signed(hfus_pkg::VZ_NORM_Q16)) ? 17'd0
                                                                           : hfus_pkg::Q16_ONE;
    if (state == hfus_pkg::S_Q_DIV_WAIT && ddone) q <= 17'(hfus_pkg::Q16_ONE - 17'(dquot));
    if (state == hfus_pkg::S_V_UPD) vtmp <= hfus_pkg::sat32(v_sum);
  end

`ifndef SYNTHESIS
  a_ci_range: assert property (@(posedge clk) disable iff (rst)
    (ci <= 32'sd131072) && (ci >= -32'sd131072))
    else $error("correction integral out of range");
  a_tf_range: assert property (@(posedge clk) disable iff (rst)
    (tf <= 17'sd32768) && (tf >= -17'sd32768))
    else $error("tilt filter out of range");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    ddone |-> (state == hfus_pkg::S_ACC_DIV_WAIT || state == hfus_pkg::S_H_DIV_WAIT ||
               state == hfus_pkg::S_Q_DIV_WAIT))
    else $error("divider finished outside a wait state");
`endif
endmodule
`default_nettype wire
